[design/bma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bma_pkg;

  localparam int MIN_LEVEL    = 3;
  localparam int MAX_LEVEL    = 18;
  localparam int HEADER_BYTES = 16;
  localparam int UNIT_SHIFT   = 6;

  localparam int LEVELS     = MAX_LEVEL + 1;
  localparam int IDX_W      = MAX_LEVEL - MIN_LEVEL;
  localparam int LINK_W     = IDX_W + 1;
  localparam int LV_W       = 5;
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 32;
  localparam int FREE_W     = 25;
  localparam int META_W     = LV_W + 2;
  localparam int MIN_SHIFT  = MIN_LEVEL + UNIT_SHIFT;
  localparam int HEAP_SHIFT = MAX_LEVEL + UNIT_SHIFT;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [LV_W-1:0]   lv_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [META_W-1:0] meta_t;

  localparam link_t NIL = link_t'(1) << IDX_W;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SEARCH, OP_POP_RD, OP_POP_WR, OP_SPLIT,
    OP_ALLOC_FIN, OP_FREE_RD, OP_FREE_MARK, OP_BUD_RD, OP_WALK_INIT, OP_WALK_RD,
    OP_WALK_ADV, OP_UNLINK, OP_MERGE, OP_PUSH, OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ok;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind_free;
    logic alloc_bad;
    logic none_free;
    logic src_gt_lv;
    logic free_bad;
    logic meta_bad;
    logic lv_top;
    logic buddy_bad;
    logic cur_end;
    logic cur_hit;
    logic out_busy;
  } sts_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_POP_RD, S_POP_WR, S_SPLIT, S_ALLOC_FIN,
    S_FREE_CHK, S_BUD, S_BUD_CHK, S_WALK_CHK, S_WALK_STEP, S_MERGE, S_PUSH,
    S_RESULT
  } state_t;

endpackage
`default_nettype wire

[design/bma_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module bma_ram #(
  parameter int AW = 15,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/bma_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module bma_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bma_pkg::cmd_t                cmd,
  output bma_pkg::sts_t                     sts,
  input  wire logic                         kind,
  input  wire logic [bma_pkg::SIZE_W-1:0]   size,
  input  wire logic [bma_pkg::ADDR_W-1:0]   address,
  input  wire logic                         cfg_we,
  input  wire logic [bma_pkg::ADDR_W-1:0]   cfg_wdata,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic                              ok,
  output logic      [bma_pkg::ADDR_W-1:0]   granted_address,
  output logic      [bma_pkg::FREE_W-1:0]   avail_bytes
);
  import bma_pkg::*;

  logic [ADDR_W-1:0] base;
  logic              kind_q;
  logic              alloc_bad;
  logic              free_bad;
  lv_t               lv;
  lv_t               src;
  idx_t              idx;
  idx_t              buddy;
  link_t             cur;
  link_t             prev;
  link_t             steps;
  idx_t              clr_cnt;
  logic [ADDR_W-1:0] grant;
  logic [FREE_W-1:0] free_total;
  link_t             heads [LEVELS];

  // Request decode
  logic [SIZE_W:0]   need;
  lv_t               lv_c;
  logic              too_big;
  logic [ADDR_W-1:0] off;
  lv_t               src_c;
  logic              none_c;

  // Memory ports
  logic  meta_we;
  idx_t  meta_waddr, meta_raddr;
  meta_t meta_wdata, meta_rdata;
  logic  link_we;
  idx_t  link_waddr, link_raddr;
  link_t link_wdata, link_rdata;

  lv_t   hsel;
  link_t head_rd;
  lv_t   s1;
  idx_t  split_b;
  idx_t  buddy_c;
  idx_t  merge_i;
  lv_t   m_order;

  bma_ram #(.AW(IDX_W), .DW(META_W)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  bma_ram #(.AW(IDX_W), .DW(LINK_W)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  always_comb begin
    need    = {1'b0, size} + (SIZE_W+1)'(HEADER_BYTES);
    too_big = need > ((SIZE_W+1)'(1) << HEAP_SHIFT);
    lv_c    = lv_t'(MAX_LEVEL);
    for (int k = MAX_LEVEL; k >= MIN_LEVEL; k--) begin
      if (need <= ((SIZE_W+1)'(1) << (k + UNIT_SHIFT))) begin
        lv_c = lv_t'(k);
      end
    end
    off = address - ADDR_W'(HEADER_BYTES) - base;

    // Lowest non-empty order at or above the needed one.
    src_c  = lv_t'(MAX_LEVEL);
    none_c = 1'b1;
    for (int k = MAX_LEVEL; k >= MIN_LEVEL; k--) begin
      if (!heads[k][IDX_W] && lv_t'(k) >= lv) begin
        src_c  = lv_t'(k);
        none_c = 1'b0;
      end
    end

    s1      = src - lv_t'(1);
    split_b = idx | (idx_t'(1) << (s1 - lv_t'(MIN_LEVEL)));
    buddy_c = idx ^ (idx_t'(1) << (lv - lv_t'(MIN_LEVEL)));
    merge_i = (buddy < idx) ? buddy : idx;
    m_order = meta_rdata[META_W-1:2];

    unique case (cmd.op)
      OP_SPLIT:               hsel = s1;
      OP_WALK_INIT, OP_PUSH:  hsel = lv;
      default:                hsel = src;
    endcase
    head_rd = heads[hsel];
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = idx;
    meta_wdata = '0;
    meta_raddr = idx;
    link_we    = 1'b0;
    link_waddr = idx;
    link_wdata = NIL;
    link_raddr = cur[IDX_W-1:0];
    unique case (cmd.op)
      OP_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt;
        meta_wdata = (clr_cnt == '0) ? {lv_t'(MAX_LEVEL), 2'b10} : '0;
        link_we    = (clr_cnt == '0);
        link_waddr = '0;
      end
      OP_POP_RD: link_raddr = head_rd[IDX_W-1:0];
      OP_POP_WR: link_we = 1'b1;
      OP_SPLIT: begin
        meta_we    = 1'b1;
        meta_waddr = split_b;
        meta_wdata = {s1, 2'b10};
        link_we    = 1'b1;
        link_waddr = split_b;
        link_wdata = head_rd;
      end
      OP_ALLOC_FIN: begin
        meta_we    = 1'b1;
        meta_wdata = {lv, 2'b01};
      end
      OP_FREE_MARK: begin
        meta_we    = 1'b1;
        meta_wdata = {m_order, 2'b10};
      end
      OP_BUD_RD: meta_raddr = buddy_c;
      OP_UNLINK: begin
        link_we    = !prev[IDX_W];
        link_waddr = prev[IDX_W-1:0];
        link_wdata = link_rdata;
      end
      OP_MERGE: begin
        meta_we    = 1'b1;
        meta_waddr = merge_i;
        meta_wdata = {lv + lv_t'(1), 2'b10};
      end
      OP_PUSH: begin
        meta_we    = 1'b1;
        meta_wdata = {lv, 2'b10};
        link_we    = 1'b1;
        link_wdata = head_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      free_total <= FREE_W'(1) << HEAP_SHIFT;
      out_valid  <= 1'b0;
      clr_cnt    <= '0;
      for (int k = 0; k < LEVELS; k++) begin
        heads[k] <= (k == MAX_LEVEL) ? '0 : NIL;
      end
    end else begin
      if (cfg_we) begin
        base <= cfg_wdata;
      end
      // A new result may replace one that is taken in the same cycle.
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + idx_t'(1);
        OP_LOAD: begin
          kind_q    <= kind;
          lv        <= lv_c;
          alloc_bad <= (size == '0) || too_big;
          free_bad  <= (off[ADDR_W-1:HEAP_SHIFT] != '0) || (off[MIN_SHIFT-1:0] != '0);
          idx       <= off[HEAP_SHIFT-1:MIN_SHIFT];
        end
        OP_SEARCH: src <= src_c;
        OP_POP_RD: idx <= head_rd[IDX_W-1:0];
        OP_POP_WR: heads[src] <= link_rdata;
        OP_SPLIT: begin
          heads[s1] <= {1'b0, split_b};
          src       <= s1;
        end
        OP_ALLOC_FIN: begin
          free_total <= free_total - (FREE_W'(1) << (lv + lv_t'(UNIT_SHIFT)));
          grant      <= base + (ADDR_W'(idx) << MIN_SHIFT) + ADDR_W'(HEADER_BYTES);
        end
        OP_FREE_MARK: begin
          lv         <= m_order;
          free_total <= free_total + (FREE_W'(1) << (m_order + lv_t'(UNIT_SHIFT)));
        end
        OP_BUD_RD: buddy <= buddy_c;
        OP_WALK_INIT: begin
          prev  <= NIL;
          cur   <= head_rd;
          steps <= '0;
        end
        OP_WALK_ADV: begin
          prev  <= cur;
          cur   <= link_rdata;
          steps <= steps + link_t'(1);
        end
        OP_UNLINK: begin
          if (prev[IDX_W]) begin
            heads[lv] <= link_rdata;
          end
        end
        OP_MERGE: begin
          idx <= merge_i;
          lv  <= lv + lv_t'(1);
        end
        OP_PUSH: heads[lv] <= {1'b0, idx};
        OP_RESULT: begin
          ok              <= cmd.ok;
          granted_address <= (cmd.ok && !kind_q) ? grant : '0;
          avail_bytes     <= free_total;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.clr_last  = &clr_cnt;
    sts.kind_free = kind_q;
    sts.alloc_bad = alloc_bad;
    sts.none_free = none_c;
    sts.src_gt_lv = src > lv;
    sts.free_bad  = free_bad;
    sts.meta_bad  = !meta_rdata[0] || (m_order < lv_t'(MIN_LEVEL))
                    || (m_order > lv_t'(MAX_LEVEL));
    sts.lv_top    = (lv == lv_t'(MAX_LEVEL));
    sts.buddy_bad = !meta_rdata[1] || (m_order != lv);
    sts.cur_end   = cur[IDX_W] || steps[IDX_W];
    sts.cur_hit   = (cur == {1'b0, buddy});
    sts.out_busy  = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

[design/bma_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bma_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bma_pkg::sts_t sts,
  output bma_pkg::cmd_t      cmd
);
  import bma_pkg::*;

  state_t state, state_next;
  logic   res_ok, res_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      res_ok <= 1'b0;
    end else begin
      state  <= state_next;
      res_ok <= res_ok_next;
    end
  end

  always_comb begin
    state_next  = state;
    res_ok_next = res_ok;
    cmd.op      = OP_NONE;
    cmd.ok      = res_ok;
    in_ready    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        res_ok_next = 1'b0;
        if (sts.kind_free) begin
          if (sts.free_bad) begin
            state_next = S_RESULT;
          end else begin
            cmd.op     = OP_FREE_RD;
            state_next = S_FREE_CHK;
          end
        end else if (sts.alloc_bad || sts.none_free) begin
          state_next = S_RESULT;
        end else begin
          cmd.op     = OP_SEARCH;
          state_next = S_POP_RD;
        end
      end
      S_POP_RD: begin
        cmd.op     = OP_POP_RD;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.op     = OP_POP_WR;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts.src_gt_lv) begin
          cmd.op = OP_SPLIT;
        end else begin
          state_next = S_ALLOC_FIN;
        end
      end
      S_ALLOC_FIN: begin
        cmd.op      = OP_ALLOC_FIN;
        res_ok_next = 1'b1;
        state_next  = S_RESULT;
      end
      S_FREE_CHK: begin
        if (sts.meta_bad) begin
          state_next = S_RESULT;
        end else begin
          cmd.op     = OP_FREE_MARK;
          state_next = S_BUD;
        end
      end
      S_BUD: begin
        if (sts.lv_top) begin
          state_next = S_PUSH;
        end else begin
          cmd.op     = OP_BUD_RD;
          state_next = S_BUD_CHK;
        end
      end
      S_BUD_CHK: begin
        if (sts.buddy_bad) begin
          state_next = S_PUSH;
        end else begin
          cmd.op     = OP_WALK_INIT;
          state_next = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        // A buddy that is not on its list ends the merging.
        if (sts.cur_end) begin
          state_next = S_PUSH;
        end else begin
          cmd.op     = OP_WALK_RD;
          state_next = S_WALK_STEP;
        end
      end
      S_WALK_STEP: begin
        if (sts.cur_hit) begin
          cmd.op     = OP_UNLINK;
          state_next = S_MERGE;
        end else begin
          cmd.op     = OP_WALK_ADV;
          state_next = S_WALK_CHK;
        end
      end
      S_MERGE: begin
        cmd.op     = OP_MERGE;
        state_next = S_BUD;
      end
      S_PUSH: begin
        cmd.op      = OP_PUSH;
        res_ok_next = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/buddy_memory_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake             Carries
// in       in_valid/in_ready     kind, size, address
// out      out_valid/out_ready   ok, granted_address, avail_bytes
// cfg      cfg_we                cfg_wdata (heap base)
// One item is handled at a time. An allocation pops a free block and splits it
// down to the needed order; a free merges the block with its buddy while that is
// free and on its list, then pushes it. After reset a clearing pass initializes
// the block metadata memory; in_ready stays low during it.
// A finished result waits in the output register while the next item is taken.
module buddy_memory_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       kind,
  input  wire logic [bma_pkg::SIZE_W-1:0] size,
  input  wire logic [bma_pkg::ADDR_W-1:0] address,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            ok,
  output logic      [bma_pkg::ADDR_W-1:0] granted_address,
  output logic      [bma_pkg::FREE_W-1:0] avail_bytes,
  input  wire logic                       cfg_we,
  input  wire logic [bma_pkg::ADDR_W-1:0] cfg_wdata
);
  import bma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bma_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  bma_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kind(kind), .size(size), .address(address),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_ready(out_ready), .out_valid(out_valid), .ok(ok),
    .granted_address(granted_address), .avail_bytes(avail_bytes)
  );
endmodule
`default_nettype wire

[bench/allocator_checker.sv]
`timescale 1ns / 1ps
module allocator_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic                       kind,
  input  wire logic [bma_pkg::SIZE_W-1:0] size,
  input  wire logic [bma_pkg::ADDR_W-1:0] address,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic                       ok,
  input  wire logic [bma_pkg::ADDR_W-1:0] granted_address,
  input  wire logic [bma_pkg::FREE_W-1:0] avail_bytes,
  input  wire logic                       cfg_we,
  input  wire logic [bma_pkg::ADDR_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending
);
  import bma_pkg::*;

  localparam int UNITS = 1 << IDX_W;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [FREE_W-1:0] free;
  } grant_t;

  link_t             heads[LEVELS];
  link_t             links[UNITS];
  lv_t               orders[UNITS];
  bit                free_mark[UNITS];
  bit                live_mark[UNITS];
  logic [FREE_W-1:0] free_sum;
  logic [ADDR_W-1:0] base;
  grant_t            grants_due[$];

  function automatic logic [FREE_W-1:0] order_bytes(int lv);
    return FREE_W'(1) << (lv + UNIT_SHIFT);
  endfunction

  function automatic void push_free(int lv, int idx);
    links[idx] = heads[lv];
    heads[lv] = link_t'(idx);
    orders[idx] = lv_t'(lv);
    free_mark[idx] = 1;
  endfunction

  function automatic bit unlink_free(int lv, int target);
    link_t prev, cur;
    prev = NIL;
    cur = heads[lv];
    for (int s = 0; s < UNITS && cur < NIL; s++) begin
      if (cur == target) begin
        if (prev == NIL) heads[lv] = links[cur];
        else links[prev] = links[cur];
        return 1;
      end
      prev = cur;
      cur = links[cur];
    end
    return 0;
  endfunction

  function automatic void reset_heap();
    for (int i = 0; i < LEVELS; i++) heads[i] = NIL;
    for (int i = 0; i < UNITS; i++) begin
      links[i] = '0;
      orders[i] = '0;
      free_mark[i] = 0;
      live_mark[i] = 0;
    end
    push_free(MAX_LEVEL, 0);
    links[0] = NIL;
    free_sum = order_bytes(MAX_LEVEL);
    base = '0;
  endfunction

  function automatic grant_t serve_request(logic k, logic [SIZE_W-1:0] sz,
                                           logic [ADDR_W-1:0] ad);
    grant_t g;
    logic [33:0] need;
    logic [ADDR_W-1:0] off;
    int lv, src, idx, bud;
    g = '0;
    if (k == KIND_ALLOC) begin
      need = 34'(sz) + HEADER_BYTES;
      lv = MIN_LEVEL;
      while (lv <= MAX_LEVEL && (34'(1) << (lv + UNIT_SHIFT)) < need) lv++;
      src = lv;
      while (src <= MAX_LEVEL && heads[src] >= NIL) src++;
      if (sz != 0 && lv <= MAX_LEVEL && src <= MAX_LEVEL) begin
        idx = heads[src];
        heads[src] = links[idx];
        links[idx] = NIL;
        free_mark[idx] = 0;
        while (src > lv) begin
          src--;
          push_free(src, idx + (1 << (src - MIN_LEVEL)));
        end
        orders[idx] = lv_t'(lv);
        live_mark[idx] = 1;
        free_sum -= order_bytes(lv);
        g.ok = 1;
        g.addr = base + (ADDR_W'(idx) << MIN_SHIFT) + HEADER_BYTES;
      end
    end else begin
      off = ad - HEADER_BYTES - base;
      idx = int'(off >> MIN_SHIFT);
      if (off < (ADDR_W'(1) << HEAP_SHIFT) && off[MIN_SHIFT-1:0] == '0 &&
          live_mark[idx] && orders[idx] >= MIN_LEVEL && orders[idx] <= MAX_LEVEL) begin
        lv = orders[idx];
        live_mark[idx] = 0;
        free_mark[idx] = 1;
        free_sum += order_bytes(lv);
        while (lv < MAX_LEVEL) begin
          bud = idx ^ (1 << (lv - MIN_LEVEL));
          if (!free_mark[bud] || orders[bud] != lv) break;
          if (!unlink_free(lv, bud)) break;
          if (bud < idx) idx = bud;
          lv++;
          orders[idx] = lv_t'(lv);
          free_mark[idx] = 1;
        end
        push_free(lv, idx);
        g.ok = 1;
      end
    end
    g.free = free_sum;
    return g;
  endfunction

  initial reset_heap();

  always @(posedge clk) begin
    grant_t e;
    if (rst) begin
      reset_heap();
      grants_due.delete();
      errors <= 0;
    end else begin
      if (cfg_we) base = cfg_wdata;
      if (in_valid && in_ready) grants_due.push_back(serve_request(kind, size, address));
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          if (errors < 10) $display("result with no item outstanding");
          errors <= errors + 1;
        end else begin
          e = grants_due.pop_front();
          if (e.ok !== ok || e.addr !== granted_address || e.free !== avail_bytes) begin
            if (errors < 10)
              $display("mismatch: expected ok=%0d addr=%h free=%0d, got ok=%0d addr=%h free=%0d",
                       e.ok, e.addr, e.free, ok, granted_address, avail_bytes);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= grants_due.size();
  end
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import bma_pkg::*;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, kind = 0, cfg_we = 0;
  logic [SIZE_W-1:0] size = '0;
  logic [ADDR_W-1:0] address = '0, cfg_wdata = '0;
  logic [ADDR_W-1:0] base_now = '0;
  wire in_ready, out_valid, ok;
  wire [ADDR_W-1:0] granted_address;
  wire [FREE_W-1:0] avail_bytes;
  int errors, pending;
  int idle_pct = 34;
  bit rx_hold = 0;
  longint cycles = 0;
  logic [ADDR_W-1:0] grants_seen[$];

  always #5 clk = ~clk;

  buddy_memory_allocator DUT (.*);

  allocator_checker checker_i (.*);

  // Remember granted addresses so that frees mostly target live blocks.
  always @(posedge clk)
    if (!rst && out_valid && out_ready && ok && granted_address != '0)
      if (grants_seen.size() < 400) grants_seen.push_back(granted_address);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= !rx_hold && ($urandom_range(99) >= idle_pct);

  task automatic send(logic k, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1;
    kind <= k;
    size <= sz;
    address <= ad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0 || in_valid) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_base(logic [ADDR_W-1:0] b);
    cfg_we <= 1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 0;
    base_now = b;
    grants_seen.delete();
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 1000);
    if (r < 90) return $urandom_range(1, 70000);
    if (r < 95) return $urandom_range(1, 1 << 24);
    return $urandom();
  endfunction

  task automatic random_item();
    int r, i;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    if (r < 50) send(KIND_ALLOC, pick_size(), ADDR_W'({$urandom(), $urandom()}));
    else if (r < 88 && grants_seen.size() > 0) begin
      i = $urandom_range(grants_seen.size() - 1);
      a = grants_seen[i];
      grants_seen.delete(i);
      send(KIND_FREE, $urandom(), a);
    end else begin
      a = ADDR_W'({$urandom(), $urandom()});
      if ($urandom_range(1)) a = base_now + HEADER_BYTES + (ADDR_W'($urandom_range(4095)) << 6);
      send(KIND_FREE, $urandom(), a);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: zero, too large, exact fits, exhaustion, bad and double frees.
    send(KIND_ALLOC, 0, '0);
    send(KIND_ALLOC, 32'hFFFF_FFFF, '0);
    send(KIND_ALLOC, (1 << 24) - HEADER_BYTES + 1, '0);
    send(KIND_ALLOC, 1, '0);
    send(KIND_ALLOC, 512 - HEADER_BYTES, '0);
    send(KIND_ALLOC, 512 - HEADER_BYTES + 1, '0);
    send(KIND_FREE, 0, 48'd16);
    send(KIND_FREE, 0, 48'd16);
    send(KIND_FREE, 0, 48'd17);
    send(KIND_FREE, 0, 48'hFFFF_FFFF_FFFF);
    send(KIND_FREE, 0, 48'd528);
    send(KIND_FREE, 0, 48'd1040);
    send(KIND_ALLOC, (1 << 24) - HEADER_BYTES, '0);
    send(KIND_ALLOC, 1, '0);
    send(KIND_FREE, 0, 48'd16);
    send(KIND_ALLOC, (1 << 24) - HEADER_BYTES, '0);
    send(KIND_FREE, 0, 48'd16);
    drain();
    set_base(48'hFFFF_FFFF_FFFF);
    send(KIND_ALLOC, 100, '0);
    send(KIND_FREE, 0, 48'd15);
    drain();
    set_base(48'h1234_5678_9A00);
    grants_seen.delete();
    for (int n = 0; n < 1800; n++) begin
      if (n == 300) begin
        idle_pct = 0;
      end
      if (n == 600) idle_pct = 34;
      if (n == 700) begin
        fork
          begin
            rx_hold = 1;
            repeat (3000) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      if (n == 1000) drain();
      if (n == 1200) begin
        drain();
        set_base('0);
      end
      if (n == 1500) begin
        drain();
        set_base(ADDR_W'({$urandom(), $urandom()}));
      end
      random_item();
    end
    drain();
    if (errors == 0 && pending == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

[buddy_memory_allocator.f]
design/bma_pkg.sv
design/bma_ram.sv
design/bma_datapath.sv
design/bma_ctrl.sv
design/buddy_memory_allocator.sv
bench/allocator_checker.sv
bench/testbench.sv
